### rtl/core/mmpa_pkg.sv
package mmpa_pkg;

    // Coordinate width of the pos_x / pos_y ports (two's complement)
    localparam int COORD_BITS = 12;
    // Magnitude bits of a non-negative coordinate
    localparam int MAG_W      = COORD_BITS - 1;

    // Width of the screen size and pitch registers
    localparam int DIM_W      = 10;
    // Common width for the coordinate against screen size compare
    localparam int CMP_W      = (MAG_W > DIM_W) ? MAG_W : DIM_W;

    localparam int OFFSET_W   = 20;
    localparam int BANK_LSB   = 13;   // bank stride 0x2000
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        MODE_LINEAR8 = 2'd0,
        MODE_PLANAR4 = 2'd1,
        MODE_ILV4_1B = 2'd2,
        MODE_ILV2_2B = 2'd3
    } t_video_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIDEO_MODE    = 2'd0,
        CFG_SCREEN_WIDTH  = 2'd1,
        CFG_SCREEN_HEIGHT = 2'd2,
        CFG_LINE_PITCH    = 2'd3
    } t_cfg_index;

    localparam t_video_mode      RST_VIDEO_MODE    = MODE_PLANAR4;
    localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 10'd640;
    localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 10'd480;
    localparam logic [DIM_W-1:0] RST_LINE_PITCH    = 10'd80;

    localparam logic [7:0] MASK_FULL  = 8'hFF;
    localparam logic [7:0] MASK_BIT7  = 8'h80;
    localparam logic [7:0] MASK_2BPP  = 8'h03;

endpackage

### rtl/core/multi_mode_pixel_address_unit.sv
// Pixel address unit for legacy PC framebuffer layouts.
//
// Input channel: one request per pixel write (i_pos_x, i_pos_y, i_pixel_color),
// taken when i_in_valid and o_in_ready are both high. Output channel: one
// framebuffer write per request (o_in_range, o_fb_offset, o_pix_mask,
// o_write_data), handed over when o_out_valid and i_out_ready are both high.
// Configuration channel: i_cfg_index selects video_mode (0), screen_width (1),
// screen_height (2) or line_pitch (3); the low bits of i_cfg_data are written
// when i_cfg_valid is high (o_cfg_ready is always high). Write it only while
// no request is in flight.
//
// Pipeline: each request goes into an input register, then one pass of
// compare, 10x10 multiply and add feeds the result register, which drives
// o_out_valid and the result outputs.
// Throughput: one request per cycle, set by the two-deep register pipeline,
// while the receiver keeps up. When the receiver stalls, the result register
// holds; one more request is still taken into the input register, after
// which o_in_ready drops. Reset clears both pipeline valid bits and loads
// the register defaults: planar 4 bpp, 640 x 480, pitch 80.
module multi_mode_pixel_address_unit
    import mmpa_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic [31:0]                 i_pixel_color,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_in_range,
    output logic [OFFSET_W-1:0]         o_fb_offset,
    output logic [7:0]                  o_pix_mask,
    output logic [7:0]                  o_write_data,

    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DIM_W-1:0]            i_cfg_data
);

    // Configuration registers
    t_video_mode        r_video_mode;
    logic [DIM_W-1:0]   r_screen_width;
    logic [DIM_W-1:0]   r_screen_height;
    logic [DIM_W-1:0]   r_line_pitch;

    // Input stage
    logic                        r_s1_valid;
    logic [COORD_BITS-1:0]       r_pos_x;
    logic [COORD_BITS-1:0]       r_pos_y;
    logic [31:0]                 r_color;

    // Result stage
    logic                        r_out_valid;
    logic                        r_in_range;
    logic [OFFSET_W-1:0]         r_fb_offset;
    logic [7:0]                  r_pix_mask;
    logic [7:0]                  r_write_data;

    logic                        out_load;
    logic                        s1_load;

    logic [CMP_W-1:0]            x_mag;
    logic [CMP_W-1:0]            y_mag;
    logic                        ok;
    logic [DIM_W-1:0]            row;
    logic [DIM_W-1:0]            col;
    logic [1:0]                  bank;
    logic [2*DIM_W-1:0]          row_bytes;
    logic [OFFSET_W:0]           offset_sum;
    logic [7:0]                  bit1_mask;
    logic [2:0]                  shift2;
    logic [7:0]                  n_pix_mask;
    logic [7:0]                  n_write_data;
    logic [OFFSET_W-1:0]         n_fb_offset;

    // Advance the result register when it is empty or being taken
    assign out_load    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || out_load;
    assign s1_load     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mode    <= RST_VIDEO_MODE;
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_line_pitch    <= RST_LINE_PITCH;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VIDEO_MODE:    r_video_mode    <= t_video_mode'(i_cfg_data[1:0]);
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                CFG_LINE_PITCH:    r_line_pitch    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold while the result stage is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_color <= i_pixel_color;
        end
    end

    // Range check: a set sign bit rejects, otherwise compare the magnitude
    assign x_mag = CMP_W'(r_pos_x[MAG_W-1:0]);
    assign y_mag = CMP_W'(r_pos_y[MAG_W-1:0]);
    assign ok    = !r_pos_x[COORD_BITS-1] && !r_pos_y[COORD_BITS-1]
                && (x_mag < CMP_W'(r_screen_width))
                && (y_mag < CMP_W'(r_screen_height));

    // Bank, row within bank and byte column per layout
    always_comb begin
        case (r_video_mode)
            MODE_LINEAR8: begin
                bank = 2'd0;
                row  = y_mag[DIM_W-1:0];
                col  = x_mag[DIM_W-1:0];
            end
            MODE_PLANAR4: begin
                bank = 2'd0;
                row  = y_mag[DIM_W-1:0];
                col  = DIM_W'(x_mag[DIM_W-1:3]);
            end
            MODE_ILV4_1B: begin
                bank = y_mag[1:0];
                row  = DIM_W'(y_mag[DIM_W-1:2]);
                col  = DIM_W'(x_mag[DIM_W-1:3]);
            end
            default: begin
                bank = {1'b0, y_mag[0]};
                row  = DIM_W'(y_mag[DIM_W-1:1]);
                col  = DIM_W'(x_mag[DIM_W-1:2]);
            end
        endcase
    end

    assign row_bytes  = row * r_line_pitch;
    assign offset_sum = (OFFSET_W+1)'({bank, {BANK_LSB{1'b0}}})
                      + (OFFSET_W+1)'(row_bytes)
                      + (OFFSET_W+1)'(col);

    assign bit1_mask = MASK_BIT7 >> x_mag[2:0];
    assign shift2    = 3'd6 - {x_mag[1:0], 1'b0};

    always_comb begin
        case (r_video_mode)
            MODE_LINEAR8: begin
                n_pix_mask   = MASK_FULL;
                n_write_data = r_color[7:0];
            end
            MODE_PLANAR4: begin
                n_pix_mask   = bit1_mask;
                n_write_data = r_color[7:0];
            end
            MODE_ILV4_1B: begin
                n_pix_mask   = bit1_mask;
                n_write_data = (|r_color) ? bit1_mask : 8'h00;
            end
            default: begin
                n_pix_mask   = MASK_2BPP << shift2;
                n_write_data = {6'b0, r_color[1:0]} << shift2;
            end
        endcase
    end

    assign n_fb_offset = offset_sum[OFFSET_W-1:0];

    // Result register: drop everything but the flag for an off-screen pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_in_range   <= ok;
            r_fb_offset  <= ok ? n_fb_offset : '0;
            r_pix_mask   <= ok ? n_pix_mask : 8'h00;
            r_write_data <= ok ? n_write_data : 8'h00;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_in_range   = r_in_range;
    assign o_fb_offset  = r_fb_offset;
    assign o_pix_mask   = r_pix_mask;
    assign o_write_data = r_write_data;

    // A held request moves into a free result register on the next edge
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_load |=> r_out_valid)
        else $error("request lost between input and result register");

    // Off-screen pixels carry no write
    a_off_screen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_in_range |->
            r_fb_offset == '0 && r_pix_mask == 8'h00 && r_write_data == 8'h00)
        else $error("off-screen result carries write fields");

    // An on-screen write always touches at least one bit
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_in_range |-> r_pix_mask != 8'h00)
        else $error("on-screen result with empty bit mask");

endmodule

### sim/multi_mode_pixel_address_unit_tb.sv
module multi_mode_pixel_address_unit_tb
    import mmpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Bank stride of the interleaved layouts and the coordinate extremes
    localparam int unsigned BANK_STRIDE = 1 << BANK_LSB;
    localparam int          COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
    localparam int          COORD_MIN   = -(1 << (COORD_BITS - 1));

    // Run shape: requests per register setting, where the long hold-off goes
    localparam int ITEMS_PER_SETTING = 120;
    localparam int PRESSURE_SETTING  = 5;
    localparam int HOLD_CYCLES       = 60;
    localparam int CYCLE_LIMIT       = 500000;

    typedef struct packed {
        logic                in_range;
        logic [OFFSET_W-1:0] fb_offset;
        logic [7:0]          pix_mask;
        logic [7:0]          write_data;
    } t_fb_write;

    typedef struct {
        t_video_mode      mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] pitch;
    } t_screen_setup;

    // Holds its own copy of the registers and the framebuffer writes still owed
    class t_write_board;
        t_video_mode      mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] pitch;
        t_fb_write        owed_writes[$];
        int unsigned      mismatches;
        int unsigned      compared;
        int unsigned      off_screen;

        function new();
            mode       = RST_VIDEO_MODE;
            width      = RST_SCREEN_WIDTH;
            height     = RST_SCREEN_HEIGHT;
            pitch      = RST_LINE_PITCH;
            mismatches = 0;
            compared   = 0;
            off_screen = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_VIDEO_MODE:    mode   = t_video_mode'(val[1:0]);
                CFG_SCREEN_WIDTH:  width  = val;
                CFG_SCREEN_HEIGHT: height = val;
                CFG_LINE_PITCH:    pitch  = val;
                default: ;
            endcase
        endfunction

        function t_fb_write predict_write(logic signed [COORD_BITS-1:0] px,
                                          logic signed [COORD_BITS-1:0] py,
                                          logic [31:0] color);
            t_fb_write   w;
            int unsigned x;
            int unsigned y;
            int unsigned sh;
            int unsigned off;
            logic [7:0]  two_bits;
            w   = '0;
            off = 0;
            x   = 32'(px[MAG_W-1:0]);
            y   = 32'(py[MAG_W-1:0]);
            // off screen: everything but the flag stays zero
            if (px[COORD_BITS-1] || py[COORD_BITS-1] || x >= width || y >= height)
                return w;
            w.in_range = 1'b1;
            case (mode)
                MODE_LINEAR8: begin
                    off          = y * pitch + x;
                    w.pix_mask   = 8'hFF;
                    w.write_data = color[7:0];
                end
                MODE_PLANAR4: begin
                    off          = y * pitch + (x >> 3);
                    w.pix_mask   = 8'h80 >> x[2:0];
                    w.write_data = color[7:0];
                end
                MODE_ILV4_1B: begin
                    off          = (y % 4) * BANK_STRIDE + (y >> 2) * pitch + (x >> 3);
                    w.pix_mask   = 8'h80 >> x[2:0];
                    w.write_data = (color != 32'd0) ? w.pix_mask : 8'h00;
                end
                default: begin
                    sh           = 6 - 2 * (x % 4);
                    off          = (y % 2) * BANK_STRIDE + (y >> 1) * pitch + (x >> 2);
                    two_bits     = {6'd0, color[1:0]};
                    w.pix_mask   = 8'h03 << sh;
                    w.write_data = two_bits << sh;
                end
            endcase
            w.fb_offset = off[OFFSET_W-1:0];
            return w;
        endfunction

        function void note_pixel(logic signed [COORD_BITS-1:0] px,
                                 logic signed [COORD_BITS-1:0] py,
                                 logic [31:0] color);
            t_fb_write w;
            w = predict_write(px, py, color);
            if (!w.in_range)
                off_screen++;
            owed_writes.push_back(w);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_write(logic rng, logic [OFFSET_W-1:0] off,
                                  logic [7:0] msk, logic [7:0] dat);
            t_fb_write want;
            if (owed_writes.size() == 0) begin
                $display("%0t: unrequested write, expected none, got %0b/0x%05h/0x%02h/0x%02h",
                         $time, rng, off, msk, dat);
                mismatches++;
                return;
            end
            want = owed_writes.pop_front();
            compared++;
            if (want.in_range !== rng)   report("in_range", want.in_range, rng);
            if (want.fb_offset !== off)  report("fb_offset", want.fb_offset, off);
            if (want.pix_mask !== msk)   report("pix_mask", want.pix_mask, msk);
            if (want.write_data !== dat) report("write_data", want.write_data, dat);
        endfunction

        function int unsigned owed_count();
            return owed_writes.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [COORD_BITS-1:0]  i_pos_x;
    logic signed [COORD_BITS-1:0]  i_pos_y;
    logic [31:0]                   i_pixel_color;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_in_range;
    logic [OFFSET_W-1:0]           o_fb_offset;
    logic [7:0]                    o_pix_mask;
    logic [7:0]                    o_write_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [DIM_W-1:0]              i_cfg_data;

    t_write_board board = new();

    // Sender and receiver idling: zero-wait stretches left, rush for the hold-off
    int unsigned send_calm    = 0;
    int unsigned recv_calm    = 0;
    int unsigned rush_left    = 0;
    int unsigned holds_asked  = 0;
    int unsigned holds_done   = 0;
    int unsigned settings_run = 0;
    int unsigned cycle_count  = 0;

    t_video_mode all_modes[4] = '{MODE_LINEAR8, MODE_PLANAR4, MODE_ILV4_1B, MODE_ILV2_2B};

    multi_mode_pixel_address_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_color (i_pixel_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_in_range    (o_in_range),
        .o_fb_offset   (o_fb_offset),
        .o_pix_mask    (o_pix_mask),
        .o_write_data  (o_write_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stalled, %0d writes still owed", $time, board.owed_count());
            $display("tb: failure");
            $finish;
        end
    end

    // Random idle wait per request or result, with occasional runs of back-to-back items
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Mostly on-screen coordinates, a share of edges and of fully random patterns
    function automatic logic signed [COORD_BITS-1:0] pick_coord(int limit);
        int v;
        case ($urandom_range(0, 9))
            0, 1: v = int'($urandom);
            2, 3: begin
                case ($urandom_range(0, 5))
                    0: v = limit - 1;
                    1: v = limit;
                    2: v = limit + 1;
                    3: v = -1;
                    4: v = COORD_MAX;
                    default: v = COORD_MIN;
                endcase
            end
            default: v = (limit > 0) ? int'($urandom_range(0, limit - 1)) : int'($urandom);
        endcase
        return COORD_BITS'(v);
    endfunction

    // Colours: zero, 2 bpp values, nonzero with a clear low byte, anything
    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom_range(0, 3);
            2: return $urandom & 32'hFFFF_FF00;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIM_W'(1);
            2: return '1;
            default: return DIM_W'($urandom_range(1, (1 << DIM_W) - 1));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // Valid stays high on return so back-to-back requests need no extra edge.
    task automatic send_pixel(input logic signed [COORD_BITS-1:0] px,
                              input logic signed [COORD_BITS-1:0] py,
                              input logic [31:0] color);
        int unsigned gap;
        if (rush_left > 0) begin
            rush_left--;
            gap = 0;
        end else begin
            gap = draw_wait(send_calm);
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pos_x       = px;
        i_pos_y       = py;
        i_pixel_color = color;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(px, py, color);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed write has come back
    task automatic drain_requests();
        i_in_valid = 1'b0;
        while (board.owed_count() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [DIM_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Only call with the block idle
    task automatic apply_setup(input t_screen_setup s);
        write_reg(CFG_VIDEO_MODE, DIM_W'(s.mode));
        write_reg(CFG_SCREEN_WIDTH, s.width);
        write_reg(CFG_SCREEN_HEIGHT, s.height);
        write_reg(CFG_LINE_PITCH, s.pitch);
        i_cfg_valid = 1'b0;
        settings_run++;
    endtask

    // Result side: random stalls per result, plus the one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (holds_done < holds_asked) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end else begin
                stall = draw_wait(recv_calm);
                if (stall > 0) begin
                    i_out_ready = 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_write(o_in_range, o_fb_offset, o_pix_mask, o_write_data);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_screen_setup plan[$];
        t_screen_setup s;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pixel_color = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_VIDEO_MODE;
        i_cfg_data    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset setting (planar, 640 x 480): corners, just off each edge, negatives
        send_pixel(0, 0, 32'h0000_00A5);
        send_pixel(639, 479, 32'hFFFF_FFFF);
        send_pixel(640, 0, 32'h0000_0001);
        send_pixel(0, 480, 32'h0000_0001);
        send_pixel(-1, 5, 32'h0000_0055);
        send_pixel(5, -1, 32'h0000_0055);
        send_pixel(COORD_MIN, COORD_MIN, 32'h8000_0000);
        send_pixel(COORD_MAX, COORD_MAX, 32'h7FFF_FFFF);
        send_pixel(7, 1, 32'h1234_5678);

        // Each mode in turn: all four line phases, zero colour, nonzero with clear low byte
        foreach (all_modes[m]) begin
            drain_requests();
            s = '{all_modes[m], DIM_W'(320), DIM_W'(200), DIM_W'(80)};
            apply_setup(s);
            send_pixel(0, 0, 32'h0000_0000);
            send_pixel(319, 199, 32'hFFFF_FFFF);
            send_pixel(1, 1, 32'h0000_0003);
            send_pixel(2, 2, 32'hFFFF_FF00);
        end

        // Extreme settings first, then random ones
        plan.push_back('{MODE_LINEAR8, '1, '1, '1});
        plan.push_back('{MODE_ILV2_2B, '1, '1, '1});
        plan.push_back('{MODE_ILV4_1B, '0, DIM_W'(480), DIM_W'(80)});
        plan.push_back('{MODE_PLANAR4, DIM_W'(640), '0, '0});
        plan.push_back('{MODE_ILV4_1B, '1, '1, '1});
        repeat (11) begin
            s = '{all_modes[$urandom_range(0, 3)], pick_dim(), pick_dim(), pick_dim()};
            plan.push_back(s);
        end

        foreach (plan[p]) begin
            drain_requests();
            apply_setup(plan[p]);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                // sometimes pause the sender mid-setting until the pipe is empty
                if (n == ITEMS_PER_SETTING / 3 && $urandom_range(0, 2) == 0)
                    drain_requests();
                // stall the receiver for a long stretch while requests keep coming
                if (p == PRESSURE_SETTING && n == ITEMS_PER_SETTING / 2) begin
                    holds_asked++;
                    rush_left = 40;
                end
                send_pixel(pick_coord(int'(plan[p].width)), pick_coord(int'(plan[p].height)),
                           pick_color());
            end
        end

        drain_requests();
        // a spurious late write would still be caught by the sink here
        repeat (4) @(posedge i_clk);

        $display("covered %0d pixel writes (%0d off screen) over %0d register settings, all modes",
                 board.compared, board.off_screen, settings_run);
        $display("receiver held off %0d time(s) for %0d cycles, %0d cycles in all",
                 holds_done, HOLD_CYCLES, cycle_count);
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### multi_mode_pixel_address_unit.f
rtl/core/mmpa_pkg.sv
rtl/core/multi_mode_pixel_address_unit.sv
sim/multi_mode_pixel_address_unit_tb.sv
